[rtl/windowed_latency_statistics_unit_defines.svh]
// Assertion macros shared by the windowed latency statistics RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef WINDOWED_LATENCY_STATISTICS_UNIT_DEFINES_SVH
`define WINDOWED_LATENCY_STATISTICS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Windowed latency statistics check failed.");

// The consequent must hold in the cycle after the antecedent.
`define WLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Windowed latency statistics check failed.");

`endif

[rtl/wls_pkg.sv]
// Package for the windowed latency statistics unit.
// Holds sizes, derived widths and the sequencer state type; no dependencies.
package wls_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int NUM_CLASSES  = 4;

    localparam int SAMPLE_W = 64;
    localparam int COUNT_W  = 11;
    localparam int CLASS_W  = 2;
    localparam int S_USER_W = 1 + CLASS_W;
    localparam int S_DATA_W = SAMPLE_W;

    localparam int OUT_FIELDS_W = COUNT_W + 3 * SAMPLE_W;
    localparam int M_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * WINDOW_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);
    localparam int SUM_W   = SAMPLE_W + PTR_W;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

[rtl/wls_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies; width and depth are set by parameters.
module wls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/windowed_latency_statistics_unit.sv]
// Records are accepted back to back while idle; each is written into the RAM when accepted.
// A query walks the window through the RAM read port, then runs the restoring divider,
// then loads the result once the output register is free to take it.
// The block takes no item from query acceptance until its result is loaded.
// Synchronous active-low reset clears pointers, counts and control state;
// the sample RAM is not cleared, and only written entries are ever read.
`include "windowed_latency_statistics_unit_defines.svh"

module windowed_latency_statistics_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [wls_pkg::S_DATA_W-1:0]  i_s_tdata,  // sample
    input  logic [wls_pkg::S_USER_W-1:0]  i_s_tuser,  // op, event_class
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [wls_pkg::M_DATA_W-1:0]  o_m_tdata   // sample_count, average, maximum, minimum
);

    import wls_pkg::*;

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_wp  [NUM_CLASSES];
    logic [CNT_W-1:0]    r_cnt [NUM_CLASSES];
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic                r_dv, n_dv;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_vld, n_out_vld;
    logic [COUNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic [SAMPLE_W-1:0] r_out_avg, n_out_avg;
    logic [SAMPLE_W-1:0] r_out_max, n_out_max;
    logic [SAMPLE_W-1:0] r_out_min, n_out_min;

    logic                in_op;
    logic [CLASS_W-1:0]  in_cls;
    logic [CLS_W-1:0]    cls_idx;
    logic                cls_ok;
    logic                accept;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]    n_wp;
    logic [CNT_W-1:0]    n_cnt;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_sub;
    logic                div_ge;

    assign in_op   = i_s_tuser[0];
    assign in_cls  = i_s_tuser[CLASS_W:1];
    assign cls_idx = CLS_W'(in_cls);
    assign cls_ok  = int'(in_cls) < NUM_CLASSES;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    assign wr_en   = accept && (in_op == OP_RECORD) && cls_ok;
    assign wr_addr = ADDR_W'(int'(cls_idx) * WINDOW_DEPTH) + ADDR_W'(r_wp[cls_idx]);
    assign n_wp    = (int'(r_wp[cls_idx]) == WINDOW_DEPTH - 1) ? '0 : r_wp[cls_idx] + 1'b1;
    assign n_cnt   = (int'(r_cnt[cls_idx]) < WINDOW_DEPTH) ? r_cnt[cls_idx] + 1'b1
                                                           : r_cnt[cls_idx];

    assign rd_en   = (r_state == S_WALK) && (r_issue < r_n);
    assign rd_addr = r_base + ADDR_W'(r_issue);

    assign rem_sh  = {r_rem, r_sum[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_n};
    assign div_ge  = rem_sh >= {1'b0, r_n};

    wls_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_issue   = r_issue;
        n_base    = r_base;
        n_dv      = r_dv;
        n_sum     = r_sum;
        n_max     = r_max;
        n_min     = r_min;
        n_rem     = r_rem;
        n_step    = r_step;
        n_out_vld = r_out_vld && !i_m_tready;
        n_out_cnt = r_out_cnt;
        n_out_avg = r_out_avg;
        n_out_max = r_out_max;
        n_out_min = r_out_min;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (in_op == OP_QUERY)) begin
                    n_state = S_WALK;
                    n_n     = cls_ok ? r_cnt[cls_idx] : '0;
                    n_base  = ADDR_W'(int'(cls_idx) * WINDOW_DEPTH);
                    n_issue = '0;
                    n_dv    = 1'b0;
                    n_sum   = '0;
                    n_max   = '0;
                    n_min   = '1;
                end
            end
            S_WALK: begin
                n_dv = rd_en;
                if (rd_en) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_dv) begin
                    n_sum = r_sum + SUM_W'(rd_data);
                    if (rd_data > r_max) begin
                        n_max = rd_data;
                    end
                    if (rd_data < r_min) begin
                        n_min = rd_data;
                    end
                end
                if (!rd_en && !r_dv) begin
                    n_state = S_DIV;
                    n_rem   = '0;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                n_sum  = {r_sum[SUM_W-2:0], div_ge};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    if (r_n == '0) begin
                        n_out_cnt = '0;
                        n_out_avg = '0;
                        n_out_max = '0;
                        n_out_min = '0;
                    end else begin
                        n_out_cnt = COUNT_W'(r_n);
                        n_out_avg = r_sum[SAMPLE_W-1:0];
                        n_out_max = r_max;
                        n_out_min = r_min;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_wp[c]  <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_dv      <= n_dv;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_wp[cls_idx]  <= n_wp;
                r_cnt[cls_idx] <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_issue   <= n_issue;
        r_base    <= n_base;
        r_sum     <= n_sum;
        r_max     <= n_max;
        r_min     <= n_min;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_out_cnt <= n_out_cnt;
        r_out_avg <= n_out_avg;
        r_out_max <= n_out_max;
        r_out_min <= n_out_min;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_DATA_W'({r_out_min, r_out_max, r_out_avg, r_out_cnt});

    `WLS_ASSERT_NOW(a_walk_in_bounds, r_state == S_WALK, r_issue <= r_n)
    `WLS_ASSERT_NOW(a_rem_below_divisor, (r_state == S_DIV) && (r_n != '0), r_rem < r_n)
    `WLS_ASSERT_NOW(a_count_in_range, r_out_vld, int'(r_out_cnt) <= WINDOW_DEPTH)
    `WLS_ASSERT_NOW(a_min_le_max, r_out_vld && (r_out_cnt != '0), r_out_min <= r_out_max)
    `WLS_ASSERT_NEXT(a_done_loads, (r_state == S_DONE) && !r_out_vld, r_out_vld)

endmodule

[tb/sv/wls_stats_checker.sv]
`timescale 1ns / 1ps
// Checker for the windowed latency statistics unit: watches both stream channels,
// predicts the statistics of each query and compares them with the returned items.
// Depends on wls_pkg for sizes, field widths and operation codes.
module wls_stats_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [wls_pkg::S_DATA_W-1:0] i_s_tdata,   // sample
    input  logic [wls_pkg::S_USER_W-1:0] i_s_tuser,   // op, event_class
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [wls_pkg::M_DATA_W-1:0] i_m_tdata,   // sample_count, average, maximum, minimum
    output int                           o_mismatch_count,
    output int                           o_pending_results
);
    import wls_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
        logic [SAMPLE_W-1:0] average;
        logic [COUNT_W-1:0]  sample_count;
    } t_window_stats;

    logic [SAMPLE_W-1:0] window_mem [NUM_CLASSES][WINDOW_DEPTH];
    logic [PTR_W-1:0]    wr_ptr [NUM_CLASSES];
    logic [COUNT_W-1:0]  fill [NUM_CLASSES];
    t_window_stats       stats_q [$];
    int                  mismatches = 0;
    t_window_stats       got;
    t_window_stats       want;
    logic [CLASS_W-1:0]  cls;

    function automatic t_window_stats class_stats(input logic [CLASS_W-1:0] c);
        t_window_stats r;
        logic [127:0]  total;
        logic [127:0]  n;
        r = '0;
        if (int'(c) < NUM_CLASSES && fill[c] != 0) begin
            n = 128'(fill[c]);
            total = '0;
            r.minimum = '1;
            for (int k = 0; k < int'(fill[c]); k++) begin
                total = total + 128'(window_mem[c][k]);
                if (window_mem[c][k] > r.maximum) r.maximum = window_mem[c][k];
                if (window_mem[c][k] < r.minimum) r.minimum = window_mem[c][k];
            end
            r.sample_count = fill[c];
            r.average = SAMPLE_W'(total / n);
        end
        return r;
    endfunction

    task automatic record_sample(input logic [CLASS_W-1:0] c, input logic [SAMPLE_W-1:0] smp);
        if (int'(c) < NUM_CLASSES) begin
            window_mem[c][wr_ptr[c]] = smp;
            wr_ptr[c] = (int'(wr_ptr[c]) == WINDOW_DEPTH - 1) ? '0 : wr_ptr[c] + 1'b1;
            if (int'(fill[c]) < WINDOW_DEPTH) fill[c] = fill[c] + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                wr_ptr[c] = '0;
                fill[c] = '0;
            end
            stats_q.delete();
            o_pending_results <= 0;
            o_mismatch_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[OUT_FIELDS_W-1:0];
                if (stats_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: count %0d avg %h max %h min %h",
                                 got.sample_count, got.average, got.maximum, got.minimum);
                end else begin
                    want = stats_q.pop_front();
                    if (got.sample_count !== want.sample_count || got.average !== want.average
                            || got.maximum !== want.maximum || got.minimum !== want.minimum) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: count exp %0d got %0d, avg exp %h got %h",
                                     want.sample_count, got.sample_count,
                                     want.average, got.average);
                            $display("          max exp %h got %h, min exp %h got %h",
                                     want.maximum, got.maximum, want.minimum, got.minimum);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cls = i_s_tuser[CLASS_W:1];
                if (i_s_tuser[0] == OP_QUERY) begin
                    stats_q.push_back(class_stats(cls));
                end else begin
                    record_sample(cls, i_s_tdata);
                end
            end
            o_pending_results <= stats_q.size();
            o_mismatch_count <= mismatches;
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the windowed latency statistics testbench: clock, reset, stimulus and verdict.
// Depends on wls_pkg, the unit under test and the wls_stats_checker module.
module tb_top;
    import wls_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 10000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;
    int                  mismatch_count;
    int                  pending_results;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    always #4 clk = ~clk;

    windowed_latency_statistics_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    wls_stats_checker stats_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .o_mismatch_count  (mismatch_count),
        .o_pending_results (pending_results)
    );

    always @(posedge clk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [CLASS_W-1:0] cls,
                             input logic [SAMPLE_W-1:0] smp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {cls, op};
        s_tdata <= smp;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic finish_pending();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return SAMPLE_W'($urandom_range(1000));
            2: return '1 - SAMPLE_W'($urandom_range(1000));
            3: return '1;
            4: return '0;
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    initial begin
        logic               op;
        logic [CLASS_W-1:0] cls;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_QUERY, 2'd0, '1);
        send_item(OP_QUERY, 2'd3, '0);
        send_item(OP_RECORD, 2'd1, '0);
        send_item(OP_QUERY, 2'd1, '0);
        send_item(OP_RECORD, 2'd1, '1);
        send_item(OP_RECORD, 2'd1, '1);
        send_item(OP_QUERY, 2'd1, '1);
        send_item(OP_RECORD, 2'd2, 64'h8000_0000_0000_0000);
        send_item(OP_RECORD, 2'd2, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_RECORD, 2'd2, 64'h1);
        send_item(OP_QUERY, 2'd2, 64'h5555_5555_5555_5555);
        send_item(OP_RECORD, 2'd3, '1);
        send_item(OP_QUERY, 2'd3, rand_sample());
        send_item(OP_RECORD, 2'd0, 64'h5555_5555_5555_5555);
        send_item(OP_RECORD, 2'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_QUERY, 2'd0, 64'hAAAA_AAAA_AAAA_AAAA);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_ITEMS == 0) begin
                finish_pending();
                case ((i / PHASE_ITEMS) % 4)
                    0: begin
                        idle_pct = 0;
                        stall_pct = 0;
                    end
                    1: begin
                        idle_pct = 86;
                        stall_pct = 0;
                    end
                    2: begin
                        idle_pct = 0;
                        stall_pct = 86;
                    end
                    default: begin
                        idle_pct = 11;
                        stall_pct = 11;
                    end
                endcase
            end
            if (i == HOLD_AT) begin
                hold_token++;
                op = OP_QUERY;
            end else begin
                op = ($urandom_range(99) < 8) ? OP_QUERY : OP_RECORD;
            end
            if (op == OP_RECORD && $urandom_range(99) < 80) begin
                cls = '0;
            end else begin
                cls = CLASS_W'($urandom_range(NUM_CLASSES - 1));
            end
            send_item(op, cls, rand_sample());
        end

        finish_pending();
        stall_pct = 0;
        repeat (WINDOW_DEPTH + 100) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
